[hdl/pvca_pkg.sv]
// Shared types, constants and codes for the priority voice channel allocator.
// Used by every module in the hdl folder; depends on nothing else.
`default_nettype none

package pvca_pkg;

   localparam int CHANNELS           = 8;
   localparam int CHAN_W             = $clog2(CHANNELS);
   localparam int CNT_W              = $clog2(CHANNELS + 1);
   localparam int MAX_DISTANCE_DEF   = 2025;
   localparam int PRIORITY_STEPS_DEF = 10;

   localparam int OPCODE_W    = 3;
   localparam int OWNER_W     = 16;
   localparam int SOUND_W     = 9;
   localparam int VOLUME_W    = 7;
   localparam int BASE_W      = 8;
   localparam int PRIO_W      = 12;
   localparam int COORD_W     = 32;
   localparam int CFG_W       = 4;
   localparam int CSR_INDEX_W = 4;

   localparam logic [OPCODE_W-1:0] OP_START      = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_STOP_OWNER = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_FINISHED   = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_UPDATE     = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_RELINK     = 3'd4;
   localparam logic [OPCODE_W-1:0] OP_STOP_ALL   = 3'd5;

   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE_CHANNELS = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_VOLUME      = 4'd1;

   localparam logic [CFG_W-1:0] ACTIVE_CHANNELS_RESET = 4'd8;
   localparam logic [CFG_W-1:0] MAX_VOLUME_RESET      = 4'd10;

   typedef struct packed {
      logic [OPCODE_W-1:0]       opcode;
      logic [OWNER_W-1:0]        origin_id;
      logic [OWNER_W-1:0]        new_origin;
      logic                      is_player;
      logic [SOUND_W-1:0]        effect_id;
      logic [VOLUME_W-1:0]       volume;
      logic [BASE_W-1:0]         base_priority;
      logic [CHAN_W-1:0]         channel_index;
      logic signed [COORD_W-1:0] dx;
      logic signed [COORD_W-1:0] dy;
   } pvca_req_type;

   typedef struct packed {
      logic                accepted;
      logic [CHAN_W-1:0]   channel;
      logic                stole;
      logic [PRIO_W-1:0]   priority_res;
      logic [CHANNELS-1:0] freed_mask;
   } pvca_rsp_type;

   typedef struct packed {
      logic [OWNER_W-1:0] owner;
      logic [SOUND_W-1:0] sound;
      logic [PRIO_W-1:0]  prio;
   } pvca_entry_type;

   typedef struct packed {
      logic                commit;
      logic [CHANNELS-1:0] release_mask;
      logic [CHANNELS-1:0] relink_mask;
      logic [OWNER_W-1:0]  relink_owner;
      logic                set_slot;
      logic                set_prio;
      logic [CHAN_W-1:0]   set_chan;
      logic [OWNER_W-1:0]  set_owner;
      logic [SOUND_W-1:0]  set_sound;
      logic [PRIO_W-1:0]   set_value;
   } pvca_apply_type;

   typedef struct packed {
      logic              done;
      logic              far;
      logic [PRIO_W-1:0] value;
   } pvca_prio_result_type;

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_ARITH   = 5'b00010,
      ST_TARGET  = 5'b00100,
      ST_SCAN    = 5'b01000,
      ST_RESOLVE = 5'b10000
   } pvca_state_type;

   typedef enum logic [5:0] {
      U_IDLE  = 6'b000001,
      U_ABS   = 6'b000010,
      U_SUM   = 6'b000100,
      U_SUB   = 6'b001000,
      U_QUANT = 6'b010000,
      U_MUL   = 6'b100000
   } pvca_unit_state_type;

endpackage

`default_nettype wire

[hdl/pvca_prio_unit.sv]
// Distance and priority unit: octagonal distance, distance band and scaled priority.
// Steps through the states U_ABS, U_SUM, U_SUB, U_QUANT and U_MUL; depends on pvca_pkg.
`default_nettype none

module pvca_prio_unit #(
   parameter int MAX_DISTANCE   = pvca_pkg::MAX_DISTANCE_DEF,
   parameter int PRIORITY_STEPS = pvca_pkg::PRIORITY_STEPS_DEF
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     start,
   input  wire logic signed [pvca_pkg::COORD_W-1:0]      dx,
   input  wire logic signed [pvca_pkg::COORD_W-1:0]      dy,
   input  wire logic [pvca_pkg::BASE_W-1:0]              base_priority,
   output pvca_pkg::pvca_prio_result_type                result
);

   localparam int STEP_RAW = MAX_DISTANCE / PRIORITY_STEPS;
   localparam int STEP     = (STEP_RAW == 0) ? 1 : STEP_RAW;
   localparam int Q_W      = $clog2(PRIORITY_STEPS + 1);
   localparam int PROD_W   = pvca_pkg::BASE_W + Q_W;
   localparam int DIST_W   = 17;
   localparam int THR_W    = 18;
   localparam int CW       = pvca_pkg::COORD_W;

   pvca_pkg::pvca_unit_state_type state_ff, state_in;
   logic [CW-1:0]                 ax_ff, ax_in, ay_ff, ay_in;
   logic [CW:0]                   sum_ff, sum_in;
   logic [CW-1:0]                 half_ff, half_in;
   logic [DIST_W-1:0]             dist_ff, dist_in;
   logic [THR_W-1:0]              thr_ff, thr_in;
   logic [Q_W-1:0]                q_ff, q_in;
   logic                          done_ff, done_in;
   logic                          far_ff, far_in;
   logic [pvca_pkg::PRIO_W-1:0]   value_ff, value_in;

   logic [CW-1:0]     dx_bits, dy_bits, lo;
   logic [CW:0]       diff;
   logic [Q_W-1:0]    factor;
   logic [PROD_W-1:0] prod;

   assign dx_bits = dx;
   assign dy_bits = dy;
   assign lo      = (ax_ff < ay_ff) ? ax_ff : ay_ff;
   assign diff    = sum_ff - {1'b0, half_ff};
   assign factor  = Q_W'(PRIORITY_STEPS) - q_ff;
   assign prod    = PROD_W'(base_priority) * PROD_W'(factor);

   always_comb begin
      state_in = state_ff;
      ax_in    = ax_ff;
      ay_in    = ay_ff;
      sum_in   = sum_ff;
      half_in  = half_ff;
      dist_in  = dist_ff;
      thr_in   = thr_ff;
      q_in     = q_ff;
      done_in  = 1'b0;
      far_in   = far_ff;
      value_in = value_ff;
      unique case (state_ff)
         pvca_pkg::U_IDLE: begin
            if (start) begin
               state_in = pvca_pkg::U_ABS;
            end
         end
         pvca_pkg::U_ABS: begin
            ax_in    = dx_bits[CW-1] ? (~dx_bits + CW'(1)) : dx_bits;
            ay_in    = dy_bits[CW-1] ? (~dy_bits + CW'(1)) : dy_bits;
            state_in = pvca_pkg::U_SUM;
         end
         pvca_pkg::U_SUM: begin
            sum_in   = {1'b0, ax_ff} + {1'b0, ay_ff};
            half_in  = {1'b0, lo[CW-1:1]};
            state_in = pvca_pkg::U_SUB;
         end
         pvca_pkg::U_SUB: begin
            dist_in  = diff[CW:CW-DIST_W+1];
            q_in     = '0;
            thr_in   = THR_W'(STEP);
            state_in = pvca_pkg::U_QUANT;
         end
         pvca_pkg::U_QUANT: begin
            if (q_ff == Q_W'(PRIORITY_STEPS) || {1'b0, dist_ff} < thr_ff) begin
               state_in = pvca_pkg::U_MUL;
            end else begin
               q_in   = q_ff + Q_W'(1);
               thr_in = thr_ff + THR_W'(STEP);
            end
         end
         pvca_pkg::U_MUL: begin
            far_in   = dist_ff >= DIST_W'(MAX_DISTANCE);
            value_in = (q_ff == Q_W'(PRIORITY_STEPS)) ? '0 : pvca_pkg::PRIO_W'(prod);
            done_in  = 1'b1;
            state_in = pvca_pkg::U_IDLE;
         end
         default: begin
            state_in = pvca_pkg::U_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pvca_pkg::U_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      ax_ff    <= ax_in;
      ay_ff    <= ay_in;
      sum_ff   <= sum_in;
      half_ff  <= half_in;
      dist_ff  <= dist_in;
      thr_ff   <= thr_in;
      q_ff     <= q_in;
      far_ff   <= far_in;
      value_ff <= value_in;
   end

   assign result.done  = done_ff;
   assign result.far   = far_ff;
   assign result.value = value_ff;

endmodule

`default_nettype wire

[hdl/pvca_table.sv]
// Channel table: owner, sound and priority of every voice channel.
// One read port and a masked update command; depends on pvca_pkg.
`default_nettype none

module pvca_table (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [pvca_pkg::CHAN_W-1:0]       rd_addr,
   output pvca_pkg::pvca_entry_type               rd_entry,
   input  wire pvca_pkg::pvca_apply_type          apply
);

   pvca_pkg::pvca_entry_type entry_ff [pvca_pkg::CHANNELS];
   pvca_pkg::pvca_entry_type entry_in [pvca_pkg::CHANNELS];

   assign rd_entry = entry_ff[rd_addr];

   always_comb begin
      for (int e = 0; e < pvca_pkg::CHANNELS; e++) begin
         entry_in[e] = entry_ff[e];
         if (apply.commit) begin
            if (apply.set_slot && apply.set_chan == pvca_pkg::CHAN_W'(e)) begin
               entry_in[e].owner = apply.set_owner;
               entry_in[e].sound = apply.set_sound;
               entry_in[e].prio  = apply.set_value;
            end else if (apply.set_prio && apply.set_chan == pvca_pkg::CHAN_W'(e)) begin
               entry_in[e].prio = apply.set_value;
            end else if (apply.release_mask[e]) begin
               entry_in[e] = '0;
            end else if (apply.relink_mask[e]) begin
               entry_in[e].owner = apply.relink_owner;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int e = 0; e < pvca_pkg::CHANNELS; e++) begin
         if (reset) begin
            entry_ff[e] <= '0;
         end else begin
            entry_ff[e] <= entry_in[e];
         end
      end
   end

endmodule

`default_nettype wire

[hdl/priority_voice_channel_allocator.sv]
// Top level of the priority voice channel allocator: sequencer, scan and decision.
// Instantiates pvca_prio_unit and pvca_table; depends on pvca_pkg.
`default_nettype none

// One transaction at a time. After a request is taken the distance unit runs its
// threshold loop to find the distance band q (0 to PRIORITY_STEPS); then the
// sequencer reads the addressed channel, scans all CHANNELS entries of the table
// through its single read port, and decides and loads the response register.
// A waiting response does not block a new request; it only holds the decision
// of the next one until it has been taken. Configuration writes are taken at
// any time and ready is always high.
module priority_voice_channel_allocator #(
   parameter int MAX_DISTANCE   = pvca_pkg::MAX_DISTANCE_DEF,
   parameter int PRIORITY_STEPS = pvca_pkg::PRIORITY_STEPS_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire pvca_pkg::pvca_req_type                req_data,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output pvca_pkg::pvca_rsp_type                     rsp_data,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [pvca_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [pvca_pkg::CFG_W-1:0]            csr_wdata
);

   localparam int N  = pvca_pkg::CHANNELS;
   localparam int CW = pvca_pkg::CHAN_W;
   localparam int KW = pvca_pkg::CNT_W;

   function automatic logic [CW:0] first_set(input logic [N-1:0] m);
      logic [CW:0] res;
      res = '0;
      for (int i = N - 1; i >= 0; i--) begin
         if (m[i]) begin
            res = {1'b1, CW'(i)};
         end
      end
      return res;
   endfunction

   pvca_pkg::pvca_state_type      state_ff, state_in;
   pvca_pkg::pvca_req_type        req_ff, req_in;
   logic [pvca_pkg::CFG_W-1:0]    active_ff, active_in, maxvol_ff, maxvol_in;
   logic [CW-1:0]                 sp_ff, sp_in, scan_ff, scan_in;
   logic [N-1:0]                  match_ff, match_in, free_ff, free_in;
   logic [N-1:0]                  qual_ff, qual_in, occ_ff, occ_in;
   logic [pvca_pkg::OWNER_W-1:0]  tgt_owner_ff, tgt_owner_in;
   logic                          tgt_sound_ff, tgt_sound_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   pvca_pkg::pvca_rsp_type        rsp_ff, rsp_in;

   pvca_pkg::pvca_prio_result_type arith;
   pvca_pkg::pvca_entry_type       rd_entry;
   pvca_pkg::pvca_apply_type       apply;
   pvca_pkg::pvca_rsp_type         decision;
   logic [CW-1:0]                  rd_addr;
   logic [KW-1:0]                  n_chan;
   logic                           fire, unit_start, idx_in_range, tgt_live, start_ok;
   logic                           scan_in_range, sp_update;
   logic [pvca_pkg::OWNER_W-1:0]   key;
   logic [CW:0]                    reuse_pick, free_pick;
   logic [CW:0]                    sp_plus;
   logic [CW-1:0]                  sp_new;
   logic                           steal_found;
   logic [CW-1:0]                  steal_chan;
   logic [KW:0]                    pos;

   pvca_prio_unit #(
      .MAX_DISTANCE   (MAX_DISTANCE),
      .PRIORITY_STEPS (PRIORITY_STEPS)
   ) u_prio_unit (
      .clock         (clock),
      .reset         (reset),
      .start         (unit_start),
      .dx            (req_ff.dx),
      .dy            (req_ff.dy),
      .base_priority (req_ff.base_priority),
      .result        (arith)
   );

   pvca_table u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_addr  (rd_addr),
      .rd_entry (rd_entry),
      .apply    (apply)
   );

   assign req_stall  = (state_ff != pvca_pkg::ST_IDLE);
   assign unit_start = (state_ff == pvca_pkg::ST_IDLE) && req_valid;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;
   assign csr_ready  = 1'b1;

   assign n_chan = (active_ff > pvca_pkg::CFG_W'(N)) ? KW'(N) : KW'(active_ff);
   assign rd_addr = (state_ff == pvca_pkg::ST_TARGET) ? req_ff.channel_index : scan_ff;
   assign key = (req_ff.opcode == pvca_pkg::OP_UPDATE) ? tgt_owner_ff : req_ff.origin_id;
   assign scan_in_range = {1'b0, scan_ff} < n_chan;
   assign idx_in_range  = {1'b0, req_ff.channel_index} < n_chan;
   assign tgt_live      = (tgt_owner_ff != '0);
   assign fire = (state_ff == pvca_pkg::ST_RESOLVE) && (!rsp_valid_ff || !rsp_stall);

   assign start_ok = (req_ff.effect_id != '0) && (req_ff.volume != '0) && (maxvol_ff != '0)
                     && (req_ff.origin_id != '0) && !arith.far;
   assign reuse_pick = first_set(match_ff);
   assign free_pick  = first_set(free_ff);
   assign sp_plus    = {1'b0, sp_ff} + (CW + 1)'(1);
   assign sp_new     = ((KW'(sp_plus) >= n_chan) ? '0 : sp_plus[CW-1:0]);

   always_comb begin
      steal_found = 1'b0;
      steal_chan  = '0;
      pos         = '0;
      for (int k = 0; k < N; k++) begin
         pos = (KW + 1)'(sp_new) + (KW + 1)'(k);
         if (pos >= {1'b0, n_chan}) begin
            pos = pos - {1'b0, n_chan};
         end
         if (!steal_found && KW'(k) < n_chan && qual_ff[pos[CW-1:0]]) begin
            steal_found = 1'b1;
            steal_chan  = pos[CW-1:0];
         end
      end
   end

   always_comb begin
      decision           = '0;
      apply              = '0;
      sp_update          = 1'b0;
      apply.commit       = fire;
      apply.set_owner    = req_ff.origin_id;
      apply.set_sound    = req_ff.effect_id;
      apply.set_value    = arith.value;
      apply.relink_owner = req_ff.new_origin;
      unique case (req_ff.opcode)
         pvca_pkg::OP_START: begin
            if (start_ok) begin
               if (!req_ff.is_player && reuse_pick[CW]) begin
                  decision.accepted   = 1'b1;
                  decision.channel    = reuse_pick[CW-1:0];
                  decision.freed_mask = match_ff;
                  apply.release_mask  = match_ff;
               end else if (free_pick[CW]) begin
                  decision.accepted = 1'b1;
                  decision.channel  = free_pick[CW-1:0];
               end else if (n_chan != '0) begin
                  sp_update = 1'b1;
                  if (steal_found) begin
                     decision.accepted   = 1'b1;
                     decision.stole      = 1'b1;
                     decision.channel    = steal_chan;
                     decision.freed_mask = N'(1) << steal_chan;
                  end
               end
               if (decision.accepted) begin
                  decision.priority_res = arith.value;
                  apply.set_slot        = 1'b1;
                  apply.set_chan        = decision.channel;
               end
            end
         end
         pvca_pkg::OP_STOP_OWNER: begin
            if (req_ff.origin_id != '0) begin
               decision.freed_mask = match_ff;
               apply.release_mask  = match_ff;
            end
         end
         pvca_pkg::OP_FINISHED: begin
            if (idx_in_range && tgt_live) begin
               decision.freed_mask = N'(1) << req_ff.channel_index;
               apply.release_mask  = N'(1) << req_ff.channel_index;
            end
         end
         pvca_pkg::OP_UPDATE: begin
            if (maxvol_ff != '0 && idx_in_range && tgt_live && tgt_sound_ff) begin
               if (arith.far) begin
                  decision.freed_mask = match_ff;
                  apply.release_mask  = match_ff;
               end else begin
                  decision.accepted     = 1'b1;
                  decision.channel      = req_ff.channel_index;
                  decision.priority_res = arith.value;
                  apply.set_prio        = 1'b1;
                  apply.set_chan        = req_ff.channel_index;
               end
            end
         end
         pvca_pkg::OP_RELINK: begin
            if (req_ff.origin_id != '0) begin
               if (req_ff.new_origin == '0) begin
                  decision.freed_mask = match_ff;
                  apply.release_mask  = match_ff;
               end else begin
                  apply.relink_mask = match_ff;
               end
            end
         end
         pvca_pkg::OP_STOP_ALL: begin
            decision.freed_mask = occ_ff;
            apply.release_mask  = '1;
         end
         default: begin
            decision = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      active_in    = active_ff;
      maxvol_in    = maxvol_ff;
      sp_in        = sp_ff;
      scan_in      = scan_ff;
      match_in     = match_ff;
      free_in      = free_ff;
      qual_in      = qual_ff;
      occ_in       = occ_ff;
      tgt_owner_in = tgt_owner_ff;
      tgt_sound_in = tgt_sound_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            pvca_pkg::CSR_ACTIVE_CHANNELS: active_in = csr_wdata;
            pvca_pkg::CSR_MAX_VOLUME:      maxvol_in = csr_wdata;
            default: begin
               active_in = active_ff;
            end
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         pvca_pkg::ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = pvca_pkg::ST_ARITH;
            end
         end
         pvca_pkg::ST_ARITH: begin
            if (arith.done) begin
               state_in = pvca_pkg::ST_TARGET;
            end
         end
         pvca_pkg::ST_TARGET: begin
            tgt_owner_in = rd_entry.owner;
            tgt_sound_in = (rd_entry.sound != '0);
            match_in     = '0;
            free_in      = '0;
            qual_in      = '0;
            occ_in       = '0;
            scan_in      = '0;
            state_in     = pvca_pkg::ST_SCAN;
         end
         pvca_pkg::ST_SCAN: begin
            match_in[scan_ff] = scan_in_range && (rd_entry.owner == key);
            free_in[scan_ff]  = scan_in_range && (rd_entry.owner == '0);
            qual_in[scan_ff]  = scan_in_range && (arith.value >= rd_entry.prio);
            occ_in[scan_ff]   = (rd_entry.owner != '0);
            if (scan_ff == CW'(N - 1)) begin
               state_in = pvca_pkg::ST_RESOLVE;
            end else begin
               scan_in = scan_ff + CW'(1);
            end
         end
         pvca_pkg::ST_RESOLVE: begin
            if (fire) begin
               rsp_valid_in = 1'b1;
               rsp_in       = decision;
               if (sp_update) begin
                  sp_in = sp_new;
               end
               state_in = pvca_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pvca_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pvca_pkg::ST_IDLE;
         active_ff    <= pvca_pkg::ACTIVE_CHANNELS_RESET;
         maxvol_ff    <= pvca_pkg::MAX_VOLUME_RESET;
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         maxvol_ff    <= maxvol_in;
         sp_ff        <= sp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff       <= req_in;
      scan_ff      <= scan_in;
      match_ff     <= match_in;
      free_ff      <= free_in;
      qual_ff      <= qual_in;
      occ_ff       <= occ_in;
      tgt_owner_ff <= tgt_owner_in;
      tgt_sound_ff <= tgt_sound_in;
      rsp_ff       <= rsp_in;
   end

endmodule

`default_nettype wire

[hdl/pvca_checker.sv]
// Port-level checks for the priority voice channel allocator, bound to the top level.
// Depends on pvca_pkg and on priority_voice_channel_allocator.
`default_nettype none

module pvca_checker (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_valid,
   input wire logic                   req_stall,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_stall,
   input wire pvca_pkg::pvca_rsp_type rsp_data
);

   // A stalled response transaction keeps its valid and its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // The block works on one request transaction at a time.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous one still in work");

   // A rejected or non-granting transaction reports no channel, steal or priority.
   a_reject_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.accepted |->
         rsp_data.channel == '0 && !rsp_data.stole && rsp_data.priority_res == '0)
      else $error("rejected transaction carries grant fields");

   // A steal grants a channel and frees exactly that one channel.
   a_steal_frees_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.stole |->
         rsp_data.accepted && $onehot(rsp_data.freed_mask)
         && rsp_data.freed_mask[rsp_data.channel])
      else $error("steal response is inconsistent");

endmodule

bind priority_voice_channel_allocator pvca_checker u_pvca_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

[test/priority_voice_channel_allocator_test.sv]
// Self-checking testbench for priority_voice_channel_allocator: directed and random transactions
// are checked against a channel table scoreboard with its own allocation predictor.
// Depends on pvca_pkg and the allocator RTL only.
`timescale 1ns / 100ps

module priority_voice_channel_allocator_test;
   import pvca_pkg::*;

   localparam int unsigned DISTANCE_BAND =
      (MAX_DISTANCE_DEF / PRIORITY_STEPS_DEF) > 0 ? MAX_DISTANCE_DEF / PRIORITY_STEPS_DEF : 1;
   localparam int unsigned DRAIN_CYCLES = 40;
   localparam int unsigned HOLD_CYCLES  = 400;
   localparam int unsigned CYCLE_LIMIT  = 600000;
   localparam int unsigned REPORT_LIMIT = 60;

   localparam logic [OPCODE_W-1:0] OP_RESERVED_LO = 3'd6;
   localparam logic [OPCODE_W-1:0] OP_RESERVED_HI = 3'd7;

   localparam logic [COORD_W-1:0] AT_ZERO      = 32'd0;
   localparam logic [COORD_W-1:0] BAND_ONE     = 32'(300 << 16);
   localparam logic [COORD_W-1:0] LAST_BAND    = 32'(2024 << 16);
   localparam logic [COORD_W-1:0] OUT_OF_RANGE = 32'(2025 << 16);
   localparam logic [COORD_W-1:0] MOST_NEG     = 32'h8000_0000;
   localparam logic [COORD_W-1:0] MOST_POS     = 32'h7FFF_FFFF;

   class channel_table_scoreboard;
      logic [OWNER_W-1:0] owner_of [CHANNELS];
      logic [SOUND_W-1:0] sound_of [CHANNELS];
      logic [PRIO_W-1:0]  prio_of  [CHANNELS];
      int unsigned        steal_ptr;
      logic [CFG_W-1:0]   active_cfg;
      logic [CFG_W-1:0]   volume_cfg;
      pvca_rsp_type       expected_outcomes [$];
      int                 mismatches;

      function new();
         foreach (owner_of[i]) release_channel(i);
         steal_ptr  = 0;
         active_cfg = ACTIVE_CHANNELS_RESET;
         volume_cfg = MAX_VOLUME_RESET;
         mismatches = 0;
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] index, logic [CFG_W-1:0] value);
         if (index == CSR_ACTIVE_CHANNELS) begin
            active_cfg = value;
         end else if (index == CSR_MAX_VOLUME) begin
            volume_cfg = value;
         end
      endfunction

      function void release_channel(int i);
         owner_of[i] = '0;
         sound_of[i] = '0;
         prio_of[i]  = '0;
      endfunction

      function logic [CHANNELS-1:0] release_owner(logic [OWNER_W-1:0] owner, int unsigned n);
         logic [CHANNELS-1:0] mask;
         mask = '0;
         for (int i = 0; i < n; i++) begin
            if (owner_of[i] == owner) begin
               release_channel(i);
               mask[i] = 1'b1;
            end
         end
         return mask;
      endfunction

      function longint unsigned octagonal_distance(logic [COORD_W-1:0] dx,
                                                   logic [COORD_W-1:0] dy);
         logic [COORD_W-1:0] ax;
         logic [COORD_W-1:0] ay;
         longint unsigned    lo;
         longint unsigned    sum;
         ax  = dx[COORD_W-1] ? -dx : dx;
         ay  = dy[COORD_W-1] ? -dy : dy;
         lo  = (ax < ay) ? ax : ay;
         sum = ax;
         sum = sum + ay - (lo >> 1);
         return sum >> 16;
      endfunction

      function logic [PRIO_W-1:0] scaled_priority(logic [BASE_W-1:0] base,
                                                  longint unsigned distance);
         longint unsigned band;
         logic [63:0]     product;
         band = distance / DISTANCE_BAND;
         if (band >= PRIORITY_STEPS_DEF) return '0;
         product = base * (PRIORITY_STEPS_DEF - band);
         return product[PRIO_W-1:0];
      endfunction

      function void apply_request(pvca_req_type r);
         pvca_rsp_type       outcome;
         int unsigned        n;
         int unsigned        slot;
         int unsigned        probe;
         int unsigned        idx;
         logic [PRIO_W-1:0]  p;
         longint unsigned    distance;
         bit                 found;
         outcome  = '0;
         found    = 1'b0;
         slot     = 0;
         idx      = r.channel_index;
         n        = (active_cfg > CHANNELS) ? CHANNELS : active_cfg;
         distance = octagonal_distance(r.dx, r.dy);
         p        = scaled_priority(r.base_priority, distance);
         case (r.opcode)
            OP_START: begin
               if (r.effect_id != 0 && r.volume != 0 && volume_cfg != 0 && r.origin_id != 0
                   && distance < MAX_DISTANCE_DEF) begin
                  if (!r.is_player) begin
                     for (int i = 0; i < n; i++) begin
                        if (!found && owner_of[i] == r.origin_id) begin
                           found = 1'b1;
                           slot  = i;
                        end
                     end
                  end
                  if (found) begin
                     outcome.freed_mask = release_owner(r.origin_id, n);
                  end else begin
                     for (int i = 0; i < n; i++) begin
                        if (!found && owner_of[i] == 0) begin
                           found = 1'b1;
                           slot  = i;
                        end
                     end
                     if (!found && n > 0) begin
                        steal_ptr = (steal_ptr + 1 >= n) ? 0 : steal_ptr + 1;
                        for (int k = 0; k < n; k++) begin
                           probe = (steal_ptr + k) % n;
                           if (!found && p >= prio_of[probe]) begin
                              found                     = 1'b1;
                              slot                      = probe;
                              outcome.stole             = 1'b1;
                              outcome.freed_mask[probe] = 1'b1;
                           end
                        end
                     end
                  end
                  if (found) begin
                     owner_of[slot]       = r.origin_id;
                     sound_of[slot]       = r.effect_id;
                     prio_of[slot]        = p;
                     outcome.accepted     = 1'b1;
                     outcome.channel      = CHAN_W'(slot);
                     outcome.priority_res = p;
                  end
               end
            end
            OP_STOP_OWNER: begin
               if (r.origin_id != 0) outcome.freed_mask = release_owner(r.origin_id, n);
            end
            OP_FINISHED: begin
               if (idx < n && owner_of[idx] != 0) begin
                  release_channel(idx);
                  outcome.freed_mask[idx] = 1'b1;
               end
            end
            OP_UPDATE: begin
               if (volume_cfg != 0 && idx < n && owner_of[idx] != 0 && sound_of[idx] != 0) begin
                  if (distance >= MAX_DISTANCE_DEF) begin
                     outcome.freed_mask = release_owner(owner_of[idx], n);
                  end else begin
                     prio_of[idx]         = p;
                     outcome.accepted     = 1'b1;
                     outcome.channel      = r.channel_index;
                     outcome.priority_res = p;
                  end
               end
            end
            OP_RELINK: begin
               if (r.origin_id != 0) begin
                  for (int i = 0; i < n; i++) begin
                     if (owner_of[i] == r.origin_id) begin
                        if (r.new_origin == 0) begin
                           release_channel(i);
                           outcome.freed_mask[i] = 1'b1;
                        end else begin
                           owner_of[i] = r.new_origin;
                        end
                     end
                  end
               end
            end
            OP_STOP_ALL: begin
               for (int i = 0; i < CHANNELS; i++) begin
                  if (owner_of[i] != 0) outcome.freed_mask[i] = 1'b1;
                  release_channel(i);
               end
            end
            default: begin
            end
         endcase
         expected_outcomes.push_back(outcome);
      endfunction

      function int outstanding();
         return expected_outcomes.size();
      endfunction

      task report(string what);
         mismatches++;
         if (mismatches <= REPORT_LIMIT) $display("MISMATCH at %0t: %s", $time, what);
      endtask

      task check_outcome(pvca_rsp_type got);
         pvca_rsp_type want;
         if (expected_outcomes.size() == 0) begin
            report($sformatf("response %h with no transaction outstanding", got));
            return;
         end
         want = expected_outcomes.pop_front();
         if (got.accepted !== want.accepted)
            report($sformatf("accepted %b, expected %b", got.accepted, want.accepted));
         if (got.channel !== want.channel)
            report($sformatf("channel %0d, expected %0d", got.channel, want.channel));
         if (got.stole !== want.stole)
            report($sformatf("stole %b, expected %b", got.stole, want.stole));
         if (got.priority_res !== want.priority_res)
            report($sformatf("priority %0d, expected %0d", got.priority_res, want.priority_res));
         if (got.freed_mask !== want.freed_mask)
            report($sformatf("freed mask %b, expected %b", got.freed_mask, want.freed_mask));
      endtask
   endclass

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   pvca_req_type           req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   pvca_rsp_type           rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]       csr_wdata = '0;

   channel_table_scoreboard board;
   bit                      calm          = 1'b0;
   int unsigned             hold_requests = 0;
   int unsigned             hold_served   = 0;
   int unsigned             hold_left     = 0;
   int unsigned             cycle_count   = 0;

   priority_voice_channel_allocator u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !calm && ($urandom_range(99) < 28);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_outcome(rsp_data);
   end

   function automatic logic [OWNER_W-1:0] pick_owner();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 70) return OWNER_W'($urandom_range(1, 5));
      if (roll < 80) return '0;
      if (roll < 90) return $urandom_range(1) ? 16'hFFFF : 16'h8000;
      return OWNER_W'($urandom);
   endfunction

   function automatic logic [COORD_W-1:0] pick_offset();
      int unsigned        roll;
      logic [COORD_W-1:0] mag;
      roll = $urandom_range(99);
      if (roll < 25) return $urandom;
      if (roll < 45) mag = $urandom_range(0, 4 << 16);
      else mag = $urandom_range(0, 2100 << 16);
      if ($urandom_range(1)) mag = -mag;
      return mag;
   endfunction

   function automatic pvca_req_type random_request();
      pvca_req_type r;
      int unsigned  roll;
      roll = $urandom_range(99);
      if (roll < 45) r.opcode = OP_START;
      else if (roll < 55) r.opcode = OP_STOP_OWNER;
      else if (roll < 65) r.opcode = OP_FINISHED;
      else if (roll < 82) r.opcode = OP_UPDATE;
      else if (roll < 92) r.opcode = OP_RELINK;
      else if (roll < 95) r.opcode = OP_STOP_ALL;
      else r.opcode = $urandom_range(1) ? OP_RESERVED_HI : OP_RESERVED_LO;
      r.origin_id     = pick_owner();
      r.new_origin    = pick_owner();
      r.is_player     = ($urandom_range(99) < 30);
      r.effect_id     = ($urandom_range(9) == 0) ? '0 : SOUND_W'($urandom_range(1, 511));
      r.volume        = ($urandom_range(9) == 0) ? '0 : VOLUME_W'($urandom_range(1, 127));
      r.base_priority = BASE_W'($urandom);
      r.channel_index = CHAN_W'($urandom);
      r.dx            = pick_offset();
      r.dy            = pick_offset();
      return r;
   endfunction

   task automatic offer(input pvca_req_type item);
      while (!calm && $urandom_range(99) < 28) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      board.apply_request(item);
      @(negedge clock);
   endtask

   task automatic drive_fields(input logic [OPCODE_W-1:0] op, input logic [OWNER_W-1:0] origin,
                               input logic [OWNER_W-1:0] new_origin, input logic player,
                               input logic [SOUND_W-1:0] sound, input logic [VOLUME_W-1:0] vol,
                               input logic [BASE_W-1:0] base, input logic [CHAN_W-1:0] idx,
                               input logic [COORD_W-1:0] dx, input logic [COORD_W-1:0] dy);
      pvca_req_type item;
      item.opcode        = op;
      item.origin_id     = origin;
      item.new_origin    = new_origin;
      item.is_player     = player;
      item.effect_id     = sound;
      item.volume        = vol;
      item.base_priority = base;
      item.channel_index = idx;
      item.dx            = dx;
      item.dy            = dy;
      offer(item);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (board.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_settings(input logic [CFG_W-1:0] active, input logic [CFG_W-1:0] volume);
      for (int r = 0; r < 2; r++) begin
         csr_valid <= 1'b1;
         csr_index <= (r == 0) ? CSR_ACTIVE_CHANNELS : CSR_MAX_VOLUME;
         csr_wdata <= (r == 0) ? active : volume;
         do @(posedge clock); while (!csr_ready);
         board.write_register(csr_index, csr_wdata);
         @(negedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic run_phase(input logic [CFG_W-1:0] active, input logic [CFG_W-1:0] volume,
                            input int items, input int calm_items, input bit squeeze);
      wait_idle();
      write_settings(active, volume);
      if (squeeze) hold_requests++;
      for (int i = 0; i < items; i++) begin
         calm = (i < calm_items);
         offer(random_request());
      end
      calm = 1'b0;
   endtask

   initial begin
      board = new();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      drive_fields(OP_START, 16'd1, 16'd0, 1'b0, 9'd1, 7'd1, 8'd255, 3'd0, AT_ZERO, AT_ZERO);
      drive_fields(OP_START, 16'd1, 16'd0, 1'b0, 9'd511, 7'd127, 8'd0, 3'd7, AT_ZERO, AT_ZERO);
      drive_fields(OP_START, 16'hFFFF, 16'd0, 1'b1, 9'd5, 7'd5, 8'd200, 3'd0, MOST_NEG, MOST_NEG);
      drive_fields(OP_START, 16'd2, 16'd0, 1'b0, 9'd2, 7'd9, 8'd50, 3'd0, LAST_BAND, AT_ZERO);
      drive_fields(OP_START, 16'd2, 16'd0, 1'b0, 9'd2, 7'd9, 8'd50, 3'd0, OUT_OF_RANGE, AT_ZERO);
      drive_fields(OP_START, 16'd7, 16'd0, 1'b0, 9'd0, 7'd9, 8'd50, 3'd0, AT_ZERO, AT_ZERO);
      drive_fields(OP_START, 16'd7, 16'd0, 1'b0, 9'd3, 7'd0, 8'd50, 3'd0, AT_ZERO, AT_ZERO);
      drive_fields(OP_START, 16'd0, 16'd0, 1'b0, 9'd3, 7'd9, 8'd50, 3'd0, AT_ZERO, AT_ZERO);
      repeat (6)
         drive_fields(OP_START, 16'd3, 16'd0, 1'b1, 9'd3, 7'd64, 8'd255, 3'd0, AT_ZERO, AT_ZERO);
      drive_fields(OP_START, 16'd4, 16'd0, 1'b1, 9'd4, 7'd64, 8'd255, 3'd0, AT_ZERO, AT_ZERO);
      drive_fields(OP_START, 16'd5, 16'd0, 1'b1, 9'd6, 7'd64, 8'd0, 3'd0, BAND_ONE, AT_ZERO);
      drive_fields(OP_UPDATE, 16'd0, 16'd0, 1'b0, 9'd0, 7'd0, 8'd7, 3'd2, BAND_ONE, AT_ZERO);
      drive_fields(OP_UPDATE, 16'd0, 16'd0, 1'b0, 9'd0, 7'd0, 8'd7, 3'd3, MOST_POS, AT_ZERO);
      drive_fields(OP_UPDATE, 16'd0, 16'd0, 1'b0, 9'd0, 7'd0, 8'd7, 3'd3, AT_ZERO, AT_ZERO);
      drive_fields(OP_FINISHED, 16'd0, 16'd0, 1'b0, 9'd0, 7'd0, 8'd0, 3'd1, AT_ZERO, AT_ZERO);
      drive_fields(OP_RELINK, 16'd5, 16'd9, 1'b0, 9'd0, 7'd0, 8'd0, 3'd0, AT_ZERO, AT_ZERO);
      drive_fields(OP_RELINK, 16'd9, 16'd0, 1'b0, 9'd0, 7'd0, 8'd0, 3'd0, AT_ZERO, AT_ZERO);
      drive_fields(OP_START, 16'd6, 16'd0, 1'b0, 9'd8, 7'd20, 8'd10, 3'd0, AT_ZERO, AT_ZERO);
      drive_fields(OP_START, 16'd7, 16'd0, 1'b1, 9'd9, 7'd20, 8'd1, 3'd0, AT_ZERO, AT_ZERO);
      drive_fields(OP_STOP_OWNER, 16'd6, 16'd0, 1'b0, 9'd0, 7'd0, 8'd0, 3'd0, AT_ZERO, AT_ZERO);
      drive_fields(OP_RESERVED_HI, 16'd7, 16'd0, 1'b0, 9'd1, 7'd1, 8'd1, 3'd1, AT_ZERO, AT_ZERO);
      drive_fields(OP_STOP_ALL, 16'd0, 16'd0, 1'b0, 9'd0, 7'd0, 8'd0, 3'd0, AT_ZERO, AT_ZERO);

      run_phase(4'd8, 4'd15, 200, 0, 1'b1);
      run_phase(4'd1, 4'd7, 120, 0, 1'b0);
      run_phase(4'd5, 4'd0, 100, 0, 1'b0);
      run_phase(4'd15, 4'd1, 150, 0, 1'b0);
      run_phase(4'd0, 4'd10, 40, 0, 1'b0);
      run_phase(4'd3, 4'd15, 150, 0, 1'b0);
      run_phase(4'd8, 4'd12, 300, 150, 1'b0);
      wait_idle();

      if (board.mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
